/* design/efba_pkg.sv */
// Package of the exact-fit bump allocator: action and status codes, sequencer states,
// memory command structs and the pointer rounding function.
// No dependencies; every other file of the block but efba_if uses it.
package efba_pkg;

  localparam int FREE_SLOTS_DEF    = 64;
  localparam int HEAP_GRANULES_DEF = 4096;

  localparam int FL_IDX_MAX_W  = 10;
  localparam int SS_SLOT_MAX_W = 16;

  localparam int ENTRY_W = 28;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int LIMIT_W = 17;

  localparam logic [3:0]  PTR_PHASE    = 4'd12;
  localparam logic [33:0] ROUND_BIAS   = 34'd3;
  localparam logic [33:0] HEADER_BYTES = 34'd4;
  localparam logic [31:0] RESET_BUMP   = 32'd12;
  localparam logic [16:0] RESET_LIMIT  = 17'd65536;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESTART = 2'd2
  } efba_action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOM  = 2'd1,
    STAT_FULL = 2'd2
  } efba_status_t;

  typedef enum logic [0:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } efba_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_BUMP_ADD,
    ST_BUMP_CHK,
    ST_BUMP_FIN,
    ST_FINISH
  } efba_state_t;

  typedef struct packed {
    logic                    rd_en;
    logic [FL_IDX_MAX_W-1:0] rd_idx;
    logic                    wr_en;
    logic [FL_IDX_MAX_W-1:0] wr_idx;
    logic [ENTRY_W-1:0]      wr_data;
  } fl_cmd_t;

  typedef struct packed {
    logic                     rd_en;
    logic [SS_SLOT_MAX_W-1:0] rd_slot;
    logic                     wr_en;
    logic [SS_SLOT_MAX_W-1:0] wr_slot;
    logic [SIZE_W-1:0]        wr_data;
  } ss_cmd_t;

  // Rounds a pointer up to the next address that is 12 modulo 16.
  function automatic logic [33:0] round_phase(input logic [33:0] p);
    logic [33:0] q;
    q = p + ROUND_BIAS;
    return {q[33:4], PTR_PHASE};
  endfunction

endpackage

/* design/efba_if.sv */
// Handshake interfaces of the exact-fit bump allocator: request and result channels.
// Depends on nothing; widths follow the fixed field widths of the block.
interface efba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] request_size;
  logic [31:0] freed_address;

  modport source(output valid, action, request_size, freed_address, input ready);
  modport sink(input valid, action, request_size, freed_address, output ready);
endinterface

interface efba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;
  logic        reused;

  modport source(output valid, block_address, status, reused, input ready);
  modport sink(input valid, block_address, status, reused, output ready);
endinterface

/* design/exact_fit_bump_allocator.sv */
// Exact-fit bump allocator: top level with the request sequencer and the result register.
// Depends on efba_pkg, efba_if, efba_free_list and efba_size_store.
//
// One request is taken at a time. Free, restart and the unused action go from idle to the
// finishing state, which loads their result into the output register once that register is free.
// Allocate scans the free list newest first through a three-stage pipe (free-list read,
// size-store read, compare), one entry a cycle; a hit is followed by compaction at one entry
// a cycle over the newer entries, and a miss is followed by the bump arithmetic and limit
// checks in the bump add, bump check and bump finish states.
// The free-list memory port sets the scan rate. The size store is indexed by the address bits
// just above the 16-byte granule, so the user must keep HEAP_GRANULES a power of two; the
// block itself does not enforce it. Neither store is cleared after reset, so no clearing pass
// is needed. A new request is taken while an earlier result still waits in the output register.
module exact_fit_bump_allocator #(
  parameter int FREE_SLOTS    = efba_pkg::FREE_SLOTS_DEF,
  parameter int HEAP_GRANULES = efba_pkg::HEAP_GRANULES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  efba_in_if.sink           in_ch,
  efba_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [31:0]       cfg_wdata
);

  localparam int IDX_W  = $clog2(FREE_SLOTS);
  localparam int CNT_W  = $clog2(FREE_SLOTS + 1);
  localparam int SLOT_W = $clog2(HEAP_GRANULES);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FREE_SLOTS);

  efba_pkg::efba_state_t  state_r, state_nxt;
  logic [31:0]            bump_r, bump_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [31:0]            base_r;
  logic [16:0]            limit_r;

  logic [15:0]            req_r, req_nxt;
  logic [IDX_W-1:0]       iss_idx_r, iss_idx_nxt;
  logic                   iss_left_r, iss_left_nxt;
  logic                   p1_v_r, p1_v_nxt;
  logic [IDX_W-1:0]       p1_idx_r, p1_idx_nxt;
  logic                   p2_v_r, p2_v_nxt;
  logic [IDX_W-1:0]       p2_idx_r, p2_idx_nxt;
  logic [27:0]            p2_entry_r, p2_entry_nxt;
  logic [CNT_W-1:0]       mv_rd_r, mv_rd_nxt;
  logic                   mv_wv_r, mv_wv_nxt;
  logic [IDX_W-1:0]       mv_wr_r, mv_wr_nxt;
  logic [33:0]            nptr_r, nptr_nxt;
  logic [34:0]            diff_r, diff_nxt;

  logic [31:0]            res_addr_r, res_addr_nxt;
  efba_pkg::efba_status_t res_status_r, res_status_nxt;
  logic                   res_reused_r, res_reused_nxt;

  logic                   out_v_r, out_v_nxt;
  logic [31:0]            out_addr_r;
  efba_pkg::efba_status_t out_status_r;
  logic                   out_reused_r;
  logic                   out_load;

  efba_pkg::fl_cmd_t      fl_cmd;
  efba_pkg::ss_cmd_t      ss_cmd;
  logic [27:0]            fl_rdata;
  logic [15:0]            ss_rdata;

  logic                   in_xfer;
  logic [33:0]            restart_ptr;
  logic [31:0]            grant_addr;
  logic                   oom;

  efba_free_list #(.DEPTH(FREE_SLOTS)) u_free_list (
    .clk     (clk),
    .cmd     (fl_cmd),
    .rd_data (fl_rdata)
  );

  efba_size_store #(.DEPTH(HEAP_GRANULES)) u_size_store (
    .clk     (clk),
    .cmd     (ss_cmd),
    .rd_data (ss_rdata)
  );

  assign in_ch.ready          = (state_r == efba_pkg::ST_IDLE);
  assign in_xfer              = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_v_r;
  assign out_ch.block_address = out_addr_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.reused        = out_reused_r;

  assign restart_ptr = efba_pkg::round_phase({2'b00, base_r});
  assign grant_addr  = bump_r + 32'd4;
  assign oom         = diff_r[34] || (diff_r[33:0] > {17'd0, limit_r}) ||
                       (nptr_r[33:32] != 2'b00);

  always_comb begin
    state_nxt      = state_r;
    bump_nxt       = bump_r;
    cnt_nxt        = cnt_r;
    req_nxt        = req_r;
    iss_idx_nxt    = iss_idx_r;
    iss_left_nxt   = iss_left_r;
    p1_v_nxt       = 1'b0;
    p1_idx_nxt     = p1_idx_r;
    p2_v_nxt       = 1'b0;
    p2_idx_nxt     = p2_idx_r;
    p2_entry_nxt   = p2_entry_r;
    mv_rd_nxt      = mv_rd_r;
    mv_wv_nxt      = 1'b0;
    mv_wr_nxt      = mv_wr_r;
    nptr_nxt       = nptr_r;
    diff_nxt       = diff_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    res_reused_nxt = res_reused_r;
    fl_cmd         = '0;
    ss_cmd         = '0;
    out_load       = 1'b0;
    out_v_nxt      = out_v_r && !out_ch.ready;

    unique case (state_r)
      efba_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_addr_nxt   = '0;
          res_status_nxt = efba_pkg::STAT_OK;
          res_reused_nxt = 1'b0;
          state_nxt      = efba_pkg::ST_FINISH;
          unique case (in_ch.action)
            efba_pkg::ACT_ALLOC: begin
              req_nxt = in_ch.request_size;
              if (cnt_r == '0) begin
                state_nxt = efba_pkg::ST_BUMP_ADD;
              end else begin
                iss_idx_nxt  = IDX_W'(cnt_r - 1'b1);
                iss_left_nxt = 1'b1;
                state_nxt    = efba_pkg::ST_SCAN;
              end
            end
            efba_pkg::ACT_FREE: begin
              if (cnt_r == FULL_CNT) begin
                res_status_nxt = efba_pkg::STAT_FULL;
              end else begin
                fl_cmd.wr_en   = 1'b1;
                fl_cmd.wr_idx  = efba_pkg::FL_IDX_MAX_W'(cnt_r[IDX_W-1:0]);
                fl_cmd.wr_data = in_ch.freed_address[31:4];
                cnt_nxt        = cnt_r + 1'b1;
              end
            end
            efba_pkg::ACT_RESTART: begin
              bump_nxt = restart_ptr[31:0];
              cnt_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      efba_pkg::ST_SCAN: begin
        fl_cmd.rd_en   = iss_left_r;
        fl_cmd.rd_idx  = efba_pkg::FL_IDX_MAX_W'(iss_idx_r);
        p1_v_nxt       = iss_left_r;
        p1_idx_nxt     = iss_idx_r;
        iss_idx_nxt    = iss_idx_r - 1'b1;
        iss_left_nxt   = iss_left_r && (iss_idx_r != '0);
        ss_cmd.rd_en   = p1_v_r;
        ss_cmd.rd_slot = efba_pkg::SS_SLOT_MAX_W'(fl_rdata[SLOT_W-1:0]);
        p2_v_nxt       = p1_v_r;
        p2_idx_nxt     = p1_idx_r;
        p2_entry_nxt   = fl_rdata;
        if (p2_v_r && (ss_rdata == req_r)) begin
          res_addr_nxt   = {p2_entry_r, 4'b0000};
          res_reused_nxt = 1'b1;
          mv_rd_nxt      = CNT_W'(p2_idx_r) + 1'b1;
          iss_left_nxt   = 1'b0;
          p1_v_nxt       = 1'b0;
          p2_v_nxt       = 1'b0;
          state_nxt      = efba_pkg::ST_COMPACT;
        end else if (!iss_left_r && !p1_v_r) begin
          state_nxt = efba_pkg::ST_BUMP_ADD;
        end
      end
      efba_pkg::ST_COMPACT: begin
        if (mv_rd_r < cnt_r) begin
          fl_cmd.rd_en  = 1'b1;
          fl_cmd.rd_idx = efba_pkg::FL_IDX_MAX_W'(mv_rd_r[IDX_W-1:0]);
          mv_rd_nxt     = mv_rd_r + 1'b1;
          mv_wv_nxt     = 1'b1;
          mv_wr_nxt     = mv_rd_r[IDX_W-1:0] - 1'b1;
        end else if (!mv_wv_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = efba_pkg::ST_FINISH;
        end
        if (mv_wv_r) begin
          fl_cmd.wr_en   = 1'b1;
          fl_cmd.wr_idx  = efba_pkg::FL_IDX_MAX_W'(mv_wr_r);
          fl_cmd.wr_data = fl_rdata;
        end
      end
      efba_pkg::ST_BUMP_ADD: begin
        nptr_nxt  = efba_pkg::round_phase({2'b00, bump_r} + efba_pkg::HEADER_BYTES +
                                          {18'd0, req_r});
        state_nxt = efba_pkg::ST_BUMP_CHK;
      end
      efba_pkg::ST_BUMP_CHK: begin
        diff_nxt  = {1'b0, nptr_r} - {3'b000, base_r};
        state_nxt = efba_pkg::ST_BUMP_FIN;
      end
      efba_pkg::ST_BUMP_FIN: begin
        if (oom) begin
          res_status_nxt = efba_pkg::STAT_OOM;
        end else begin
          res_addr_nxt   = grant_addr;
          ss_cmd.wr_en   = 1'b1;
          ss_cmd.wr_slot = efba_pkg::SS_SLOT_MAX_W'(grant_addr[SLOT_W+3:4]);
          ss_cmd.wr_data = req_r;
          bump_nxt       = nptr_r[31:0];
        end
        state_nxt = efba_pkg::ST_FINISH;
      end
      efba_pkg::ST_FINISH: begin
        if (!out_v_r || out_ch.ready) begin
          out_load  = 1'b1;
          out_v_nxt = 1'b1;
          state_nxt = efba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = efba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= efba_pkg::ST_IDLE;
      bump_r     <= efba_pkg::RESET_BUMP;
      cnt_r      <= '0;
      base_r     <= '0;
      limit_r    <= efba_pkg::RESET_LIMIT;
      iss_left_r <= 1'b0;
      p1_v_r     <= 1'b0;
      p2_v_r     <= 1'b0;
      mv_wv_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bump_r     <= bump_nxt;
      cnt_r      <= cnt_nxt;
      iss_left_r <= iss_left_nxt;
      p1_v_r     <= p1_v_nxt;
      p2_v_r     <= p2_v_nxt;
      mv_wv_r    <= mv_wv_nxt;
      out_v_r    <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          efba_pkg::REG_HEAP_BASE:  base_r  <= cfg_wdata;
          efba_pkg::REG_HEAP_LIMIT: limit_r <= cfg_wdata[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    iss_idx_r    <= iss_idx_nxt;
    p1_idx_r     <= p1_idx_nxt;
    p2_idx_r     <= p2_idx_nxt;
    p2_entry_r   <= p2_entry_nxt;
    mv_rd_r      <= mv_rd_nxt;
    mv_wr_r      <= mv_wr_nxt;
    nptr_r       <= nptr_nxt;
    diff_r       <= diff_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    res_reused_r <= res_reused_nxt;
    if (out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_reused_r <= res_reused_r;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("Free-list count exceeds the number of slots.");

  a_ptr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r[3:0] == efba_pkg::PTR_PHASE)
    else $error("Bump pointer left the 12 modulo 16 phase.");

  a_no_wr_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == efba_pkg::ST_SCAN) |-> !fl_cmd.wr_en)
    else $error("Free list written during a scan.");

  a_oom_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_status_r == efba_pkg::STAT_OOM)) |-> ((out_addr_r == '0) && !out_reused_r))
    else $error("Out-of-memory result carries an address or a reuse flag.");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r == efba_pkg::ST_FINISH))
    else $error("Result raised outside the finishing step.");
`endif

endmodule

/* design/efba_free_list.sv */
// Free-list store of the exact-fit bump allocator: one write and one registered read a cycle.
// Depends on efba_pkg for the command struct.
module efba_free_list #(
  parameter int DEPTH = efba_pkg::FREE_SLOTS_DEF
) (
  input  logic                            clk,
  input  efba_pkg::fl_cmd_t               cmd,
  output logic [efba_pkg::ENTRY_W-1:0]    rd_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [efba_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_idx[IDX_W-1:0]] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_idx[IDX_W-1:0]];
    end
  end

endmodule

/* design/efba_size_store.sv */
// Block size store of the exact-fit bump allocator, indexed by granule slot.
// Depends on efba_pkg for the command struct; one write and one registered read a cycle.
module efba_size_store #(
  parameter int DEPTH = efba_pkg::HEAP_GRANULES_DEF
) (
  input  logic                          clk,
  input  efba_pkg::ss_cmd_t             cmd,
  output logic [efba_pkg::SIZE_W-1:0]   rd_data
);

  localparam int SLOT_W = $clog2(DEPTH);

  logic [efba_pkg::SIZE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_slot[SLOT_W-1:0]] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_slot[SLOT_W-1:0]];
    end
  end

endmodule

/* dv/efba_checker.sv */
`timescale 1ns / 100ps
// Result checker for the exact-fit bump allocator: watches the request, result and
// register ports, predicts each result and compares it. Depends on efba_pkg and efba_if.
module efba_checker #(
  parameter int FREE_SLOTS    = efba_pkg::FREE_SLOTS_DEF,
  parameter int HEAP_GRANULES = efba_pkg::HEAP_GRANULES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  efba_in_if          in_mon,
  efba_out_if         out_mon,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  output int unsigned fail_count,
  output int unsigned grants_waiting
);
  import efba_pkg::*;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
    logic        reused;
  } grant_t;

  logic [31:0] heap_base_q;
  logic [16:0] heap_limit_q;
  logic [31:0] bump_ptr;
  int          free_cnt;
  logic [27:0] free_entry [FREE_SLOTS];
  logic [15:0] size_of [HEAP_GRANULES];
  grant_t      pending_grants [$];
  int unsigned results_seen;

  function automatic logic [33:0] to_phase(input logic [33:0] p);
    logic [3:0] adj;
    adj = PTR_PHASE - p[3:0];
    return p + {30'd0, adj};
  endfunction

  function automatic int size_slot(input logic [31:0] a);
    return int'((a >> 4) % HEAP_GRANULES);
  endfunction

  function automatic void restart_heap();
    logic [33:0] p;
    p = to_phase({2'b00, heap_base_q});
    bump_ptr = p[31:0];
    free_cnt = 0;
  endfunction

  function automatic grant_t serve_request(input logic [1:0] act, input logic [15:0] req,
                                           input logic [31:0] faddr);
    grant_t      g;
    logic [33:0] nxt;
    logic [31:0] a;
    int          k;
    int          j;
    bit          hit;
    g   = '0;
    hit = 1'b0;
    case (act)
      ACT_ALLOC: begin
        k = free_cnt - 1;
        while (!hit && k >= 0) begin
          a = {free_entry[k], 4'h0};
          if (size_of[size_slot(a)] == req) begin
            hit = 1'b1;
            for (j = k; j < free_cnt - 1; j++) free_entry[j] = free_entry[j + 1];
            free_cnt--;
            g.block_address = a;
            g.reused        = 1'b1;
          end
          k--;
        end
        if (!hit) begin
          nxt = to_phase({2'b00, bump_ptr} + 34'd4 + {18'd0, req});
          if (nxt < {2'b00, heap_base_q} ||
              nxt - {2'b00, heap_base_q} > {17'd0, heap_limit_q} ||
              nxt > 34'h0_FFFF_FFFF) begin
            g.status = STAT_OOM;
          end else begin
            a = bump_ptr + 32'd4;
            g.block_address = a;
            size_of[size_slot(a)] = req;
            bump_ptr = nxt[31:0];
          end
        end
      end
      ACT_FREE: begin
        if (free_cnt >= FREE_SLOTS) begin
          g.status = STAT_FULL;
        end else begin
          free_entry[free_cnt] = faddr[31:4];
          free_cnt++;
        end
      end
      ACT_RESTART: begin
        restart_heap();
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  initial begin
    fail_count     = 0;
    grants_waiting = 0;
    results_seen   = 0;
  end

  always @(posedge clk) begin
    grant_t seen;
    grant_t want;
    if (!rst_n) begin
      heap_base_q  = 32'd0;
      heap_limit_q = RESET_LIMIT;
      restart_heap();
      pending_grants.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.block_address = out_mon.block_address;
        seen.status        = out_mon.status;
        seen.reused        = out_mon.reused;
        results_seen++;
        if (pending_grants.size() == 0) begin
          fail_count++;
          $display("%0t: expected no result, got addr %h status %0d reused %0d", $time,
                   seen.block_address, seen.status, seen.reused);
        end else begin
          want = pending_grants.pop_front();
          if (seen.block_address !== want.block_address || seen.status !== want.status ||
              seen.reused !== want.reused) begin
            fail_count++;
            $display("%0t: result %0d: expected addr %h status %0d reused %0d,",
                     $time, results_seen, want.block_address, want.status, want.reused);
            $display("%0t: result %0d: got addr %h status %0d reused %0d",
                     $time, results_seen, seen.block_address, seen.status, seen.reused);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == REG_HEAP_BASE) heap_base_q = cfg_wdata;
        else heap_limit_q = cfg_wdata[16:0];
      end
      if (in_mon.valid && in_mon.ready)
        pending_grants.push_back(serve_request(in_mon.action, in_mon.request_size,
                                               in_mon.freed_address));
    end
    grants_waiting = pending_grants.size();
  end

endmodule

/* dv/tb_exact_fit_bump_allocator.sv */
`timescale 1ns / 100ps
// Testbench top for the exact-fit bump allocator: clock, reset, request and register
// stimulus, random back-pressure and the verdict. Depends on efba_pkg, efba_if and efba_checker.
module tb_exact_fit_bump_allocator;
  import efba_pkg::*;

  localparam int          WATCHDOG_CYCLES = 2000;
  localparam int          SLOT_W          = $clog2(HEAP_GRANULES_DEF);
  localparam logic [1:0]  ACT_UNUSED      = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_wdata;

  efba_in_if  in_ch();
  efba_out_if out_ch();

  int unsigned fail_count;
  int unsigned grants_waiting;
  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_reused;
  int unsigned n_oom;
  int unsigned n_full;
  int unsigned n_settings;
  int unsigned idle_cycles;
  int          gap_pct;
  int          stall_pct;
  bit                slot_granted [HEAP_GRANULES_DEF];
  logic [SLOT_W-1:0] granted_slots [$];

  exact_fit_bump_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  efba_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .grants_waiting(grants_waiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Only addresses whose size slot has been written by a granted block may be freed.
  always @(posedge clk) begin
    logic busy;
    busy = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        n_sent++;
        busy = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        busy = 1'b1;
        if (out_ch.reused) n_reused++;
        if (out_ch.status == STAT_OOM) n_oom++;
        if (out_ch.status == STAT_FULL) n_full++;
        if (out_ch.status == STAT_OK && out_ch.block_address != 32'd0 &&
            !slot_granted[out_ch.block_address[SLOT_W+3:4]]) begin
          slot_granted[out_ch.block_address[SLOT_W+3:4]] = 1'b1;
          granted_slots.push_back(out_ch.block_address[SLOT_W+3:4]);
        end
      end
    end
    if (busy) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("FAIL exact_fit_bump_allocator");
      $finish;
    end
  end

  function automatic int gap_length(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 6))
        0: return 16'd0;
        1: return 16'd4;
        2: return 16'd12;
        3: return 16'd16;
        4: return 16'd28;
        5: return 16'd60;
        default: return 16'd100;
      endcase
    end
    if (r < 70) return 16'($urandom_range(0, 255));
    if (r < 90) return 16'($urandom_range(0, 4095));
    if (r < 95) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] pick_freed_address();
    logic [31:0] a;
    a = $urandom;
    a[SLOT_W+3:4] = granted_slots[$urandom_range(0, granted_slots.size() - 1)];
    if ($urandom_range(0, 1)) a[3:0] = 4'h0;
    if ($urandom_range(0, 1)) a[31:16] = 16'h0;
    return a;
  endfunction

  task automatic issue(input logic [1:0] act, input logic [15:0] req, input logic [31:0] faddr);
    int gap;
    gap = gap_length(gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid         <= 1'b0;
      in_ch.action        <= 2'($urandom);
      in_ch.request_size  <= 16'($urandom);
      in_ch.freed_address <= $urandom;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.request_size  <= req;
    in_ch.freed_address <= faddr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (n_results != n_sent) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input efba_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_heap(input logic [31:0] base, input logic [16:0] limit);
    go_idle();
    write_reg(REG_HEAP_BASE, base);
    write_reg(REG_HEAP_LIMIT, {15'd0, limit});
    n_settings++;
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [16:0] limit, input bit restart,
                           input int count, input int free_pct, input int restart_pct,
                           input int gaps, input int stalls);
    int r;
    set_heap(base, limit);
    gap_pct   = gaps;
    stall_pct = stalls;
    if (restart) issue(ACT_RESTART, 16'($urandom), $urandom);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < restart_pct)
        issue(ACT_RESTART, 16'($urandom), $urandom);
      else if (r < restart_pct + 3)
        issue(ACT_UNUSED, 16'($urandom), $urandom);
      else if (r < restart_pct + 3 + free_pct && granted_slots.size() > 0)
        issue(ACT_FREE, 16'($urandom), pick_freed_address());
      else
        issue(ACT_ALLOC, pick_size(), $urandom);
    end
  endtask

  initial begin
    stall_pct = 0;
    out_ch.ready = 1'b0;
    forever begin
      int stall;
      @(negedge clk);
      stall = gap_length(stall_pct);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_HEAP_BASE;
    cfg_wdata           = 32'd0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_ALLOC;
    in_ch.request_size  = 16'd0;
    in_ch.freed_address = 32'd0;
    gap_pct             = 0;
    n_sent              = 0;
    n_results           = 0;
    n_reused            = 0;
    n_oom               = 0;
    n_full              = 0;
    n_settings          = 1;
    idle_cycles         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fresh heap at reset settings: zero and maximum sizes, then exact-fit reuse newest first,
    // an unaligned and aliased free, the unused action and a restart.
    issue(ACT_ALLOC, 16'd0, 32'd0);
    issue(ACT_ALLOC, 16'hFFFF, 32'd0);
    issue(ACT_ALLOC, 16'd12, 32'd0);
    issue(ACT_ALLOC, 16'd12, 32'd0);
    issue(ACT_ALLOC, 16'd100, 32'd0);
    issue(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    go_idle();
    issue(ACT_FREE, 16'd0, 32'hFFFF_002F);
    issue(ACT_FREE, 16'd0, 32'h0000_0030);
    issue(ACT_FREE, 16'd0, 32'h0000_0010);
    issue(ACT_ALLOC, 16'd12, 32'd0);
    issue(ACT_ALLOC, 16'd12, 32'd0);
    issue(ACT_ALLOC, 16'd0, 32'd0);
    issue(ACT_ALLOC, 16'd0, 32'd0);
    issue(ACT_FREE, 16'd0, 32'h0000_0030);
    issue(ACT_RESTART, 16'd0, 32'd0);
    issue(ACT_ALLOC, 16'd12, 32'd0);

    // Limits at their extremes: no room at all, the top of the address space, a base whose
    // first phase-aligned pointer wraps below it.
    set_heap(32'd0, 17'd0);
    issue(ACT_ALLOC, 16'd0, 32'd0);
    set_heap(32'hFFFF_FFF0, 17'd65536);
    issue(ACT_RESTART, 16'd0, 32'd0);
    issue(ACT_ALLOC, 16'd0, 32'd0);
    set_heap(32'hFFFF_FFFF, 17'd65536);
    issue(ACT_RESTART, 16'd0, 32'd0);
    issue(ACT_ALLOC, 16'd0, 32'd0);

    run_phase(32'd0, 17'd65536, 1'b1, 90, 40, 3, 0, 0);
    run_phase($urandom, 17'($urandom_range(256, 65536)), 1'b1, 80, 40, 3, 30, 30);
    run_phase(32'h0000_1000, 17'($urandom_range(0, 65536)), 1'b0, 60, 40, 3, 10, 0);
    run_phase(32'd0, 17'd65536, 1'b1, 160, 75, 0, 20, 40);
    run_phase($urandom, 17'd65536, 1'b0, 50, 40, 5, 0, 20);
    run_phase(32'hFFFF_0000, 17'd65536, 1'b1, 80, 40, 4, 15, 15);
    run_phase(32'h7FFF_FFF4, 17'($urandom_range(0, 64)), 1'b1, 50, 40, 3, 5, 5);
    run_phase(32'd0, 17'd65536, 1'b1, 70, 45, 3, 50, 50);

    go_idle();
    repeat (20) @(negedge clk);
    $display("Run covered %0d requests over %0d heap settings, %0d results checked.",
             n_sent, n_settings, n_results);
    $display("Free-list reuses %0d, out-of-memory answers %0d, full-free-list answers %0d.",
             n_reused, n_oom, n_full);
    if (fail_count == 0 && grants_waiting == 0) begin
      $display("PASS exact_fit_bump_allocator");
    end else begin
      $display("FAIL exact_fit_bump_allocator");
    end
    $finish;
  end

endmodule

/* sim.f */
design/efba_pkg.sv
design/efba_if.sv
design/efba_free_list.sv
design/efba_size_store.sv
design/exact_fit_bump_allocator.sv
dv/efba_checker.sv
dv/tb_exact_fit_bump_allocator.sv
